FILE: rtl/psc_pkg.sv
// Shared types and constants for the packet sum checker.
package psc_pkg;

  // Byte positions within a 12-byte packet.
  localparam logic [3:0] POS_FIRST = 4'd0;
  localparam logic [3:0] SUM_BYTES = 4'd10;
  localparam logic [3:0] POS_HIGH  = 4'd10;
  localparam logic [3:0] POS_LOW   = 4'd11;

  // Register reset values.
  localparam logic [5:0] PACKETS_PER_BUFFER_RESET  = 6'd42;
  localparam logic [5:0] MANY_FAIL_THRESHOLD_RESET = 6'd20;

  // Register map, indexed by word address.
  typedef enum logic {
    REG_PACKETS_PER_BUFFER,
    REG_MANY_FAIL_THRESHOLD
  } reg_index_t;

  // Status reported on the last packet of a buffer.
  typedef enum logic [1:0] {
    STATUS_NONE,
    STATUS_SOME,
    STATUS_MANY,
    STATUS_ALL
  } buffer_status_t;

  // Configuration seen by the buffer logic.
  typedef struct packed {
    logic [5:0] packets_per_buffer;
    logic [5:0] many_fail_threshold;
  } cfg_t;

  // Per-byte view of the packet currently being framed.
  typedef struct packed {
    logic       last;
    logic       failed;
    logic [7:0] channel;
  } frame_info_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0]     channel;
    logic           failed;
    logic [5:0]     number;
    logic           done;
    logic [5:0]     failures;
    buffer_status_t status;
  } result_t;

endpackage

FILE: rtl/psc_regs.sv
// APB-style configuration registers of the packet sum checker.
module psc_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output psc_pkg::cfg_t    cfg
);
  import psc_pkg::*;

  reg_index_t reg_index;
  logic       wr_en;

  assign pready    = 1'b1;
  assign reg_index = reg_index_t'(paddr[2]);
  assign wr_en     = psel && penable && pwrite;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.packets_per_buffer  <= PACKETS_PER_BUFFER_RESET;
      cfg.many_fail_threshold <= MANY_FAIL_THRESHOLD_RESET;
    end else if (wr_en) begin
      case (reg_index)
        REG_PACKETS_PER_BUFFER:  cfg.packets_per_buffer  <= pwdata[5:0];
        REG_MANY_FAIL_THRESHOLD: cfg.many_fail_threshold <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // Read data, zero-extended.
  always_comb begin
    case (reg_index)
      REG_PACKETS_PER_BUFFER:  prdata = {26'd0, cfg.packets_per_buffer};
      REG_MANY_FAIL_THRESHOLD: prdata = {26'd0, cfg.many_fail_threshold};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/psc_frame.sv
// Packet framing: byte position, running sum and received checksum.
module psc_frame (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           byte_in,
  output psc_pkg::frame_info_t info
);
  import psc_pkg::*;

  logic [3:0]  pos;
  logic [11:0] running_sum;
  logic [11:0] running_sum_next;
  logic [7:0]  received_high;
  logic [7:0]  first_byte;
  logic [15:0] received;

  // The received checksum is complete once the low byte is present.
  assign running_sum_next = running_sum + {4'd0, byte_in};
  assign received         = {received_high, byte_in};
  assign info.last        = (pos == POS_LOW);
  assign info.failed      = (received != {4'd0, running_sum});
  assign info.channel     = first_byte;

  // Advance the framing state on each consumed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= POS_FIRST;
      running_sum   <= 12'd0;
      received_high <= 8'd0;
      first_byte    <= 8'd0;
    end else if (step) begin
      if (pos == POS_LOW) begin
        pos           <= POS_FIRST;
        running_sum   <= 12'd0;
        received_high <= 8'd0;
      end else begin
        pos <= pos + 4'd1;
        if (pos == POS_FIRST) begin
          first_byte <= byte_in;
        end
        if (pos < SUM_BYTES) begin
          running_sum <= running_sum_next;
        end
        if (pos == POS_HIGH) begin
          received_high <= byte_in;
        end
      end
    end
  end

endmodule

FILE: rtl/psc_buffer.sv
// Buffer bookkeeping: packet index, failure count and buffer status.
module psc_buffer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  psc_pkg::cfg_t        cfg,
  input  psc_pkg::frame_info_t info,
  output psc_pkg::result_t     result
);
  import psc_pkg::*;

  logic [5:0] packet_index;
  logic [5:0] fail_count;
  logic [5:0] fail_count_next;
  logic [5:0] eff_size;
  logic       done;

  // A buffer size of zero behaves as one packet per buffer.
  assign eff_size        = (cfg.packets_per_buffer == 6'd0) ? 6'd1 : cfg.packets_per_buffer;
  assign fail_count_next = fail_count + {5'd0, info.failed};
  assign done            = ({1'b0, packet_index} + 7'd1) >= {1'b0, eff_size};

  // Assemble the result for the packet that ends with this byte.
  always_comb begin
    result.channel  = info.channel;
    result.failed   = info.failed;
    result.number   = packet_index;
    result.done     = done;
    result.failures = fail_count_next;
    result.status   = STATUS_NONE;
    if (done) begin
      if (fail_count_next >= eff_size) begin
        result.status = STATUS_ALL;
      end else if (fail_count_next > cfg.many_fail_threshold) begin
        result.status = STATUS_MANY;
      end else if (fail_count_next != 6'd0) begin
        result.status = STATUS_SOME;
      end
    end
  end

  // Update the counters at each packet end; both clear when a buffer closes.
  always_ff @(posedge clk) begin
    if (rst) begin
      packet_index <= 6'd0;
      fail_count   <= 6'd0;
    end else if (step) begin
      if (done) begin
        packet_index <= 6'd0;
        fail_count   <= 6'd0;
      end else begin
        packet_index <= packet_index + 6'd1;
        fail_count   <= fail_count_next;
      end
    end
  end

endmodule

FILE: rtl/packet_sum_checker.sv
// Packet sum checker top level: input register, checking logic, result register.
// A byte accepted into the input register is checked there; a packet's last byte
// loads its result, and raises result_valid, once the result register is free.
// Throughput: one byte per cycle, one result per 12 bytes; the input stalls
// only when a packet end meets a result register that is still held.
// Synchronous active-high reset clears state and valid flags, loads register defaults.
module packet_sum_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [7:0]  data_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [7:0]  channel_byte,
  output logic        packet_failed,
  output logic [5:0]  packet_number,
  output logic        buffer_done,
  output logic [5:0]  buffer_failures,
  output logic [1:0]  buffer_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import psc_pkg::*;

  cfg_t        cfg;
  frame_info_t info;
  result_t     result;
  result_t     result_q;
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        out_free;
  logic        in_go;
  logic        packet_end;

  // Configuration registers.
  psc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Framing and checksum.
  psc_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .step    (in_go),
    .byte_in (in_byte),
    .info    (info)
  );

  // Buffer counters and status.
  psc_buffer u_buffer (
    .clk    (clk),
    .rst    (rst),
    .step   (packet_end),
    .cfg    (cfg),
    .info   (info),
    .result (result)
  );

  // A registered byte moves on unless it ends a packet and the result slot is held.
  assign out_free   = !result_valid || result_ready;
  assign in_go      = in_valid && (!info.last || out_free);
  assign packet_end = in_go && info.last;
  assign data_ready = !in_valid || in_go;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (data_ready) begin
      in_valid <= data_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && data_ready) begin
      in_byte <= data_byte;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (packet_end) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (packet_end) begin
      result_q <= result;
    end
  end

  assign channel_byte    = result_q.channel;
  assign packet_failed   = result_q.failed;
  assign packet_number   = result_q.number;
  assign buffer_done     = result_q.done;
  assign buffer_failures = result_q.failures;
  assign buffer_status   = result_q.status;

  // A status other than none is only reported on the last packet of a buffer.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !buffer_done |-> buffer_status == STATUS_NONE)
    else $error("buffer status reported outside a buffer end");

  // A failed packet is always included in the failure count.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && packet_failed |-> buffer_failures != 6'd0)
    else $error("failed packet missing from failure count");

  // A packet end is never taken while an untaken result is still held.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !packet_end)
    else $error("result register overwritten");

  // Nothing is reported straight after reset.
  assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid after reset");

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the packet sum checker: byte stream in, packet verdicts out.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import psc_pkg::*;

  // One byte waiting to be offered; wait_drain holds it back until no verdict is outstanding.
  typedef struct {
    logic [7:0] value;
    bit         wait_drain;
  } stream_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        data_valid = 1'b0;
  logic        data_ready;
  logic [7:0]  data_byte = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [7:0]  channel_byte;
  logic        packet_failed;
  logic [5:0]  packet_number;
  logic        buffer_done;
  logic [5:0]  buffer_failures;
  logic [1:0]  buffer_status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Bytes still to be sent and packet verdicts still to arrive.
  stream_byte_t stream_bytes[$];
  result_t      packet_verdicts[$];

  // Idling percentages and the long receiver hold-off.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  logic        hold_start = 1'b0;
  int unsigned hold_left = 0;

  int unsigned mismatches = 0;
  int unsigned verdicts_seen = 0;

  // Checker state as the block should hold it.
  logic [5:0]  cfg_ppb = PACKETS_PER_BUFFER_RESET;
  logic [5:0]  cfg_thr = MANY_FAIL_THRESHOLD_RESET;
  logic [3:0]  byte_pos = '0;
  logic [11:0] sum_acc = '0;
  logic [7:0]  high_seen = '0;
  logic [7:0]  first_seen = '0;
  logic [5:0]  pkt_in_buffer = '0;
  logic [5:0]  fails_in_buffer = '0;

  packet_sum_checker dut (
    .clk             (clk),
    .rst             (rst),
    .data_valid      (data_valid),
    .data_ready      (data_ready),
    .data_byte       (data_byte),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .channel_byte    (channel_byte),
    .packet_failed   (packet_failed),
    .packet_number   (packet_number),
    .buffer_done     (buffer_done),
    .buffer_failures (buffer_failures),
    .buffer_status   (buffer_status),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #5 clk = ~clk;

  // Advance the checksum state by one byte; a packet end yields one verdict.
  function automatic void checksum_step(logic [7:0] b);
    logic [15:0] received;
    logic [5:0]  eff;
    logic        failed;
    logic        last;
    result_t     r;
    if (byte_pos == POS_FIRST) first_seen = b;
    if (byte_pos < SUM_BYTES) sum_acc = sum_acc + 12'(b);
    if (byte_pos == POS_HIGH) high_seen = b;
    if (byte_pos != POS_LOW) begin
      byte_pos = byte_pos + 4'd1;
      return;
    end
    received = {high_seen, b};
    failed = received != {4'd0, sum_acc};
    // A buffer size of zero behaves as a size of one.
    eff = (cfg_ppb == 6'd0) ? 6'd1 : cfg_ppb;
    if (failed) fails_in_buffer = fails_in_buffer + 6'd1;
    last = ({1'b0, pkt_in_buffer} + 7'd1) >= {1'b0, eff};
    r.channel = first_seen;
    r.failed = failed;
    r.number = pkt_in_buffer;
    r.done = last;
    r.failures = fails_in_buffer;
    r.status = STATUS_NONE;
    if (last) begin
      if (fails_in_buffer >= eff) r.status = STATUS_ALL;
      else if (fails_in_buffer > cfg_thr) r.status = STATUS_MANY;
      else if (fails_in_buffer != 6'd0) r.status = STATUS_SOME;
    end
    packet_verdicts.push_back(r);
    if (last) begin
      pkt_in_buffer = '0;
      fails_in_buffer = '0;
    end else begin
      pkt_in_buffer = pkt_in_buffer + 6'd1;
    end
    byte_pos = '0;
    sum_acc = '0;
    high_seen = '0;
  endfunction

  // Count a mismatch and report the first few in full.
  task automatic flag_mismatch(string field, logic [7:0] want, logic [7:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("verdict %0d: %s expected %0h got %0h", verdicts_seen, field, want, got);
  endtask

  // Sender: offers queued bytes, with random idle cycles, and predicts each accepted one.
  always @(posedge clk) begin : sender
    stream_byte_t item;
    bit           offer;
    if (rst) begin
      data_valid <= 1'b0;
    end else begin
      if (data_valid && data_ready) checksum_step(data_byte);
      if (!data_valid || data_ready) begin
        offer = stream_bytes.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct;
        if (offer && stream_bytes[0].wait_drain && packet_verdicts.size() != 0) offer = 1'b0;
        if (offer) begin
          item = stream_bytes.pop_front();
          data_byte <= item.value;
          data_valid <= 1'b1;
        end else begin
          data_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down here.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= 300;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: checks each verdict transaction against the oldest prediction.
  always @(posedge clk) begin : receiver
    result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (packet_verdicts.size() == 0) begin
          flag_mismatch("unexpected verdict, channel", 8'h00, channel_byte);
        end else begin
          want = packet_verdicts.pop_front();
          if (channel_byte !== want.channel)
            flag_mismatch("channel_byte", want.channel, channel_byte);
          if (packet_failed !== want.failed)
            flag_mismatch("packet_failed", 8'(want.failed), 8'(packet_failed));
          if (packet_number !== want.number)
            flag_mismatch("packet_number", 8'(want.number), 8'(packet_number));
          if (buffer_done !== want.done)
            flag_mismatch("buffer_done", 8'(want.done), 8'(buffer_done));
          if (buffer_failures !== want.failures)
            flag_mismatch("buffer_failures", 8'(want.failures), 8'(buffer_failures));
          if (buffer_status !== want.status)
            flag_mismatch("buffer_status", 8'(want.status), 8'(buffer_status));
        end
        verdicts_seen++;
      end
      result_ready <= (hold_left == 0) && ($urandom_range(99, 0) >= rx_stall_pct);
    end
  end

  task automatic push_byte(logic [7:0] value);
    stream_bytes.push_back('{value, 1'b0});
  endtask

  // Queue one packet with a correct or a corrupted checksum.
  task automatic queue_packet(bit corrupt);
    logic [15:0] sum;
    logic [15:0] check;
    logic [7:0]  b;
    sum = '0;
    for (int i = 0; i < 10; i++) begin
      case ($urandom_range(7, 0))
        0: b = 8'h00;
        1: b = 8'hFF;
        default: b = 8'($urandom());
      endcase
      sum = sum + 16'(b);
      push_byte(b);
    end
    check = sum;
    if (corrupt) begin
      // Either a single flipped bit or an arbitrary wrong value.
      if ($urandom_range(1, 0) == 0) begin
        check = sum ^ (16'd1 << $urandom_range(15, 0));
      end else begin
        do check = 16'($urandom()); while (check == sum);
      end
    end
    push_byte(check[15:8]);
    push_byte(check[7:0]);
  endtask

  task automatic queue_packets(int count, int unsigned fail_pct);
    for (int i = 0; i < count; i++) queue_packet($urandom_range(99, 0) < fail_pct);
  endtask

  task automatic set_idling(int unsigned tx_pct, int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  // Wait until every byte is sent and every verdict is in, then let the pipeline settle.
  task automatic wait_until_drained();
    do @(negedge clk);
    while (stream_bytes.size() != 0 || data_valid || packet_verdicts.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_register(reg_index_t idx, logic [5:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {26'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PACKETS_PER_BUFFER:  cfg_ppb = value;
      REG_MANY_FAIL_THRESHOLD: cfg_thr = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  initial begin : stimulus
    stream_byte_t carry[$];
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: largest possible sum passing, then all-zero bytes with an all-ones checksum.
    set_idling(0, 0);
    for (int i = 0; i < 10; i++) push_byte(8'hFF);
    push_byte(8'h09);
    push_byte(8'hF6);
    for (int i = 0; i < 10; i++) push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'hFF);
    queue_packets(2, 50);
    wait_until_drained();

    // Small buffers with a low threshold, so that every status can occur.
    write_register(REG_PACKETS_PER_BUFFER, 6'd4);
    write_register(REG_MANY_FAIL_THRESHOLD, 6'd1);
    set_idling(62, 0);
    queue_packets(8, 40);
    wait_until_drained();

    // One packet per buffer, lowest threshold.
    write_register(REG_PACKETS_PER_BUFFER, 6'd1);
    write_register(REG_MANY_FAIL_THRESHOLD, 6'd0);
    set_idling(0, 62);
    queue_packets(6, 50);
    wait_until_drained();

    // A buffer size of zero, highest threshold.
    write_register(REG_PACKETS_PER_BUFFER, 6'd0);
    write_register(REG_MANY_FAIL_THRESHOLD, 6'd63);
    set_idling(20, 20);
    queue_packets(4, 50);
    wait_until_drained();

    // Largest buffer, left part-way through a buffer and part-way through a packet.
    write_register(REG_PACKETS_PER_BUFFER, 6'd63);
    write_register(REG_MANY_FAIL_THRESHOLD, 6'd2);
    set_idling(62, 0);
    queue_packets(4, 30);
    queue_packet(1'b1);
    for (int i = 0; i < 6; i++) carry.push_front(stream_bytes.pop_back());
    wait_until_drained();

    // Buffer size lowered below the packets already seen; then every packet fails.
    write_register(REG_PACKETS_PER_BUFFER, 6'd3);
    write_register(REG_MANY_FAIL_THRESHOLD, 6'd0);
    set_idling(0, 62);
    while (carry.size() != 0) stream_bytes.push_back(carry.pop_front());
    queue_packets(6, 100);
    wait_until_drained();

    // Receiver held off while the sender keeps going; later the sender waits for a drain.
    write_register(REG_PACKETS_PER_BUFFER, 6'd5);
    write_register(REG_MANY_FAIL_THRESHOLD, 6'd2);
    set_idling(0, 0);
    queue_packets(10, 50);
    stream_bytes[60].wait_drain = 1'b1;
    @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    wait_until_drained();

    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: packet_sum_checker.f
rtl/psc_pkg.sv
rtl/psc_regs.sv
rtl/psc_frame.sv
rtl/psc_buffer.sv
rtl/packet_sum_checker.sv
bench/tb_top.sv
